// ===== hw/rtl/pidw_pkg.sv =====
`timescale 1ns / 1ps

package pidw_pkg;

  // field and register widths
  localparam int DATA_W      = 16;
  localparam int REG_W       = 16;
  localparam int DRIVE_W     = 32;
  localparam int INT_SHIFT   = 7;
  localparam int PROP_SHIFT  = 4;
  localparam int DERIV_SHIFT = 1;

  // derived widths
  localparam int ERR_W       = DATA_W + 1;
  localparam int PROD_W      = REG_W + ERR_W;
  localparam int INTEG_W     = REG_W + INT_SHIFT + 1;
  localparam int ISUM_W      = PROD_W + 1;
  localparam int DSUM_W      = PROD_W + 2;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = ((2 * DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DRIVE_W + 7) / 8) * 8;

  // rounding offsets for truncation toward zero
  localparam logic signed [PROD_W-1:0]  PROP_RND  = PROD_W'((2 ** PROP_SHIFT) - 1);
  localparam logic signed [PROD_W-1:0]  DERIV_RND = PROD_W'((2 ** DERIV_SHIFT) - 1);
  localparam logic signed [INTEG_W-1:0] INT_RND   = INTEG_W'((2 ** INT_SHIFT) - 1);

  // reset values of the limit registers
  localparam logic signed [REG_W-1:0] LOWER_RST = {1'b1, {(REG_W-1){1'b0}}};
  localparam logic signed [REG_W-1:0] UPPER_RST = {1'b0, {(REG_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_LOWER = 3'd3,
    REG_UPPER = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [REG_W-1:0] kp;
    logic signed [REG_W-1:0] ki;
    logic signed [REG_W-1:0] kd;
    logic signed [REG_W-1:0] lower_limit;
    logic signed [REG_W-1:0] upper_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] p_prod;
    logic signed [PROD_W-1:0] i_prod;
    logic signed [PROD_W-1:0] d_prod;
  } terms_t;

  typedef struct packed {
    logic signed [PROD_W-1:0]  p_prod;
    logic signed [PROD_W-1:0]  d_prod;
    logic signed [INTEG_W-1:0] integ;
  } integ_t;

endpackage

// ===== hw/rtl/pidw_cfg.sv =====
`timescale 1ns / 1ps

module pidw_cfg import pidw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp          <= '0;
      cfg.ki          <= '0;
      cfg.kd          <= '0;
      cfg.lower_limit <= LOWER_RST;
      cfg.upper_limit <= UPPER_RST;
    end else if (cfg_wen) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_KP:    cfg.kp          <= $signed(cfg_wdata);
        REG_KI:    cfg.ki          <= $signed(cfg_wdata);
        REG_KD:    cfg.kd          <= $signed(cfg_wdata);
        REG_LOWER: cfg.lower_limit <= $signed(cfg_wdata);
        REG_UPPER: cfg.upper_limit <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pidw_terms.sv =====
`timescale 1ns / 1ps

module pidw_terms import pidw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ld,
  input  logic signed [DATA_W-1:0] measured,
  input  logic signed [DATA_W-1:0] setpoint,
  input  cfg_t                     cfg,
  output terms_t                   terms
);

  logic signed [DATA_W-1:0] last_measured;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  der;

  // error on setpoint, derivative on measurement only
  always_comb begin
    err = ERR_W'(setpoint) - ERR_W'(measured);
    der = ERR_W'(last_measured) - ERR_W'(measured);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_measured <= '0;
    end else if (ld) begin
      last_measured <= measured;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      terms.p_prod <= PROD_W'(cfg.kp) * PROD_W'(err);
      terms.i_prod <= PROD_W'(cfg.ki) * PROD_W'(err);
      terms.d_prod <= PROD_W'(cfg.kd) * PROD_W'(der);
    end
  end

endmodule

// ===== hw/rtl/pidw_integ.sv =====
`timescale 1ns / 1ps

module pidw_integ import pidw_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   ld,
  input  terms_t terms,
  input  cfg_t   cfg,
  output integ_t integ_out
);

  logic signed [INTEG_W-1:0] integral;
  logic signed [INTEG_W-1:0] integral_next;
  logic signed [INTEG_W-1:0] hi;
  logic signed [INTEG_W-1:0] lo;
  logic signed [ISUM_W-1:0]  isum;

  // clamp with the upper bound tested first
  always_comb begin
    hi   = INTEG_W'(cfg.upper_limit) <<< INT_SHIFT;
    lo   = INTEG_W'(cfg.lower_limit) <<< INT_SHIFT;
    isum = ISUM_W'(integral) + ISUM_W'(terms.i_prod);
    if (isum > ISUM_W'(hi)) begin
      integral_next = hi;
    end else if (isum < ISUM_W'(lo)) begin
      integral_next = lo;
    end else begin
      integral_next = isum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else if (ld) begin
      integral <= integral_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      integ_out.p_prod <= terms.p_prod;
      integ_out.d_prod <= terms.d_prod;
      integ_out.integ  <= integral_next;
    end
  end

  a_integ_hold: assert property (@(posedge clk) disable iff (rst)
    !ld |=> $stable(integral))
    else $error("integral changed without a request");

  a_integ_bounds: assert property (@(posedge clk) disable iff (rst)
    ld && (cfg.lower_limit <= cfg.upper_limit)
      |=> (integral <= $past(hi)) && (integral >= $past(lo)))
    else $error("integral outside its limits");

endmodule

// ===== hw/rtl/integer_pid_anti_windup_unit.sv =====
`timescale 1ns / 1ps
// pipeline: the input register loads on the accepting edge, then the product,
//   integrator (combinational add and clamp) and output registers drive m_tvalid
// throughput: one request per cycle when m_tready does not stall the output
// reset: synchronous rst clears all stage valids, the stored measurement and
//   the integral, gains to zero and limits to the full 16-bit range

module integer_pid_anti_windup_unit import pidw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // slave request channel
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // measured [15:0], setpoint [31:16]
  // master result channel
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // drive [31:0]
  // register write port
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_wdata
);

  cfg_t   cfg;
  terms_t terms;
  integ_t integ_q;

  // stage valids: input reg, products, integrator, output reg
  logic in_valid;
  logic prod_valid;
  logic integ_valid;
  logic out_valid;

  // per-stage ready chain so bubbles are squeezed out under backpressure
  logic out_rdy;
  logic integ_rdy;
  logic prod_rdy;
  logic in_rdy;
  logic prod_ld;
  logic integ_ld;
  logic out_ld;

  logic signed [DATA_W-1:0] measured;
  logic signed [DATA_W-1:0] setpoint;

  // output stage arithmetic
  logic signed [PROD_W-1:0]  p_adj;
  logic signed [PROD_W-1:0]  d_adj;
  logic signed [INTEG_W-1:0] i_adj;
  logic signed [PROD_W-1:0]  p_div;
  logic signed [PROD_W-1:0]  d_div;
  logic signed [INTEG_W-1:0] i_div;
  logic signed [DSUM_W-1:0]  drive_sum;

  always_comb begin
    out_rdy   = !out_valid || m_tready;
    integ_rdy = !integ_valid || out_rdy;
    prod_rdy  = !prod_valid || integ_rdy;
    in_rdy    = !in_valid || prod_rdy;
    prod_ld   = in_valid && prod_rdy;
    integ_ld  = prod_valid && integ_rdy;
    out_ld    = integ_valid && out_rdy;
  end

  assign s_tready = in_rdy;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      prod_valid  <= 1'b0;
      integ_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_valid <= s_tvalid;
      end
      if (prod_rdy) begin
        prod_valid <= in_valid;
      end
      if (integ_rdy) begin
        integ_valid <= prod_valid;
      end
      if (out_rdy) begin
        out_valid <= integ_valid;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s_tvalid && in_rdy) begin
      measured <= $signed(s_tdata[DATA_W-1:0]);
      setpoint <= $signed(s_tdata[2*DATA_W-1:DATA_W]);
    end
  end

  pidw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // error, derivative and the three gain products
  pidw_terms u_terms (
    .clk      (clk),
    .rst      (rst),
    .ld       (prod_ld),
    .measured (measured),
    .setpoint (setpoint),
    .cfg      (cfg),
    .terms    (terms)
  );

  // integral accumulate and anti-windup clamp
  pidw_integ u_integ (
    .clk       (clk),
    .rst       (rst),
    .ld        (integ_ld),
    .terms     (terms),
    .cfg       (cfg),
    .integ_out (integ_q)
  );

  // scale each term with truncation toward zero: bias negatives, then shift
  always_comb begin
    p_adj = integ_q.p_prod[PROD_W-1] ? integ_q.p_prod + PROP_RND : integ_q.p_prod;
    d_adj = integ_q.d_prod[PROD_W-1] ? integ_q.d_prod + DERIV_RND : integ_q.d_prod;
    i_adj = integ_q.integ[INTEG_W-1] ? integ_q.integ + INT_RND : integ_q.integ;
    p_div = p_adj >>> PROP_SHIFT;
    d_div = d_adj >>> DERIV_SHIFT;
    i_div = i_adj >>> INT_SHIFT;
    drive_sum = DSUM_W'(p_div) + DSUM_W'(i_div) + DSUM_W'(d_div);
  end

  // result register, drive wraps to its low bits
  always_ff @(posedge clk) begin
    if (out_ld) begin
      m_tdata <= OUT_TDATA_W'(drive_sum[DRIVE_W-1:0]);
    end
  end

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("pipeline blocked with an empty output register");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted request lost at the input register");

  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    integ_valid && !m_tvalid |=> m_tvalid)
    else $error("integrator result did not reach the output register");

  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !integ_valid |=> !m_tvalid)
    else $error("result repeated after it was taken");

endmodule

// ===== tb/tb_integer_pid_anti_windup_unit.sv =====
`timescale 1ns / 1ps

import pidw_pkg::*;

// expected drive values, worked out from the gains, limits and controller state
class drive_scoreboard;

  // mirrored gain and limit registers
  logic signed [REG_W-1:0]   kp;
  logic signed [REG_W-1:0]   ki;
  logic signed [REG_W-1:0]   kd;
  logic signed [REG_W-1:0]   lower_limit;
  logic signed [REG_W-1:0]   upper_limit;
  // mirrored controller state
  logic signed [DATA_W-1:0]  last_meas;
  logic signed [INTEG_W-1:0] integ;

  logic [DRIVE_W-1:0] pending_drive[$];
  int                 errors;

  function new();
    kp          = '0;
    ki          = '0;
    kd          = '0;
    lower_limit = LOWER_RST;
    upper_limit = UPPER_RST;
    last_meas   = '0;
    integ       = '0;
    errors      = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    case (idx)
      REG_KP:    kp = val;
      REG_KI:    ki = val;
      REG_KD:    kd = val;
      REG_LOWER: lower_limit = val;
      REG_UPPER: upper_limit = val;
      default: ;
    endcase
  endfunction

  // one accepted request: update the controller state and queue its drive
  function void take_sample(logic signed [DATA_W-1:0] meas, logic signed [DATA_W-1:0] setp);
    longint err;
    longint der;
    longint hi;
    longint lo;
    longint sum;
    longint drive;
    longint scale;
    scale = longint'(2 ** INT_SHIFT);
    err   = longint'(setp) - longint'(meas);
    der   = longint'(last_meas) - longint'(meas);
    hi    = longint'(upper_limit) * scale;
    lo    = longint'(lower_limit) * scale;
    last_meas = meas;
    sum = longint'(integ) + longint'(ki) * err;
    // the upper bound is tested first, which decides the result when the limits are crossed
    if (sum > hi)
      sum = hi;
    else if (sum < lo)
      sum = lo;
    integ = INTEG_W'(sum);
    // each term divides separately, truncating toward zero
    drive = (longint'(kp) * err) / longint'(2 ** PROP_SHIFT)
          + longint'(integ) / scale
          + (longint'(kd) * der) / longint'(2 ** DERIV_SHIFT);
    pending_drive.push_back(drive[DRIVE_W-1:0]);
  endfunction

  function void check_drive(logic [DRIVE_W-1:0] actual);
    logic [DRIVE_W-1:0] want;
    if (pending_drive.size() == 0) begin
      errors++;
      $display("%0t: unexpected drive result, expected none actual %0d",
               $time, $signed(actual));
      return;
    end
    want = pending_drive.pop_front();
    if (want !== actual) begin
      errors++;
      $display("%0t: drive mismatch, expected %0d actual %0d",
               $time, $signed(want), $signed(actual));
    end
  endfunction
endclass

module tb_integer_pid_anti_windup_unit;
  import pidw_pkg::*;

  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int SETTLE_CYCLES = 10;   // margin after the last result for the pipeline to empty
  localparam int RAND_PHASES   = 12;

  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [REG_W-1:0]  GAIN_MIN = LOWER_RST;
  localparam logic signed [REG_W-1:0]  GAIN_MAX = UPPER_RST;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [REG_W-1:0]       cfg_wdata = '0;

  // when set, neither side inserts gaps or stalls
  bit quiet = 1'b0;

  drive_scoreboard sb = new();

  integer_pid_anti_windup_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [REG_W-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return GAIN_MIN;
      1: return GAIN_MAX;
      2: return '0;
      3, 4: return REG_W'(int'($urandom_range(0, 128)) - 64);
      default: return REG_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_level();
    case ($urandom_range(0, 9))
      0: return DATA_MIN;
      1: return DATA_MAX;
      2, 3, 4: return DATA_W'(int'($urandom_range(0, 600)) - 300);
      default: return DATA_W'($urandom());
    endcase
  endfunction

  // result side: ready held high for a while, then an optional stall
  initial begin
    int n;
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      n = quiet ? 0 : idle_len();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // every drive result accepted is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_drive(m_tdata[DRIVE_W-1:0]);
  end

  // register write, with the enable taken low again before the task returns
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_wen   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_gains(input logic signed [REG_W-1:0] p, input logic signed [REG_W-1:0] i,
                             input logic signed [REG_W-1:0] d,
                             input logic signed [REG_W-1:0] lo,
                             input logic signed [REG_W-1:0] hi);
    write_reg(REG_KP, p);
    write_reg(REG_KI, i);
    write_reg(REG_KD, d);
    write_reg(REG_LOWER, lo);
    write_reg(REG_UPPER, hi);
  endtask

  // one request; valid stays high into the next call unless a gap is wanted
  task automatic send_sample(input logic signed [DATA_W-1:0] meas,
                             input logic signed [DATA_W-1:0] setp);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= IN_TDATA_W'($urandom());
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({setp, meas});
    do @(posedge clk); while (!s_tready);
    sb.take_sample(meas, setp);
  endtask

  // let every predicted drive come out and the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic signed [REG_W-1:0]  a;
    logic signed [REG_W-1:0]  b;
    logic signed [DATA_W-1:0] setp;
    logic signed [DATA_W-1:0] meas;
    int                       count;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset gains: zero gains give zero drive
    send_sample('0, '0);
    send_sample(DATA_MAX, DATA_MIN);
    settle();

    // largest positive gains, full limits: integral hits both rails
    write_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MIN, GAIN_MAX);
    send_sample(DATA_MIN, DATA_MAX);
    send_sample(DATA_MAX, DATA_MIN);
    send_sample(DATA_MAX, DATA_MAX);
    send_sample(DATA_MIN, DATA_MIN);
    send_sample('0, '0);
    send_sample(-16'sd1, 16'sd1);
    settle();

    // most negative gains
    write_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MAX);
    send_sample(DATA_MIN, DATA_MAX);
    send_sample(DATA_MAX, DATA_MIN);
    send_sample(DATA_MIN, DATA_MAX);
    send_sample(DATA_MAX, DATA_MAX);
    settle();

    // crossed limits, odd gains so the truncation toward zero shows
    write_gains(16'sd3, 16'sd1000, 16'sd1, 16'sd200, -16'sd200);
    send_sample('0, 16'sd100);
    send_sample('0, -16'sd100);
    send_sample(-16'sd7, -16'sd7);
    send_sample(16'sd5, -16'sd7);
    settle();

    // writes to unmapped indexes must leave the registers alone
    for (int k = int'(REG_UPPER) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), REG_W'($urandom()));
    send_sample(16'sd9, -16'sd3);
    send_sample(-16'sd11, 16'sd4);
    settle();

    // random settings, each followed by a run of samples
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      a = rand_gain();
      b = rand_gain();
      if ((a > b) == ($urandom_range(0, 4) == 0))
        write_gains(rand_gain(), rand_gain(), rand_gain(), a, b);
      else
        write_gains(rand_gain(), rand_gain(), rand_gain(), b, a);
      quiet = ($urandom_range(0, 3) == 0);
      count = $urandom_range(30, 60);
      setp  = rand_level();
      for (int n = 0; n < count; n++) begin
        // the setpoint moves now and then; the measurement mostly tracks it
        if ($urandom_range(0, 9) == 0)
          setp = rand_level();
        if ($urandom_range(0, 1) == 0)
          meas = setp + DATA_W'(int'($urandom_range(0, 40)) - 20);
        else
          meas = rand_level();
        send_sample(meas, setp);
      end
      settle();
      quiet = 1'b0;
    end

    if (sb.pending_drive.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d drive results never arrived", $time, sb.pending_drive.size());
    end
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
